// ===== sv/bffpa_pkg.sv =====
// Shared types and constants of the bitmap first-fit page allocator.
// Used by the word scan, the core, the checker and the testbench; no dependencies.
package bffpa_pkg;

  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned WORD_SHIFT = 5;
  localparam int unsigned PAGE_SHIFT = 12;

  localparam logic [15:0] POOL_PAGES_RESET = 16'd32768;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_OUTSIDE   = 2'd3
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic {
    CFG_POOL_BASE  = 1'b0,
    CFG_POOL_PAGES = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic                  hit;
    logic [WORD_SHIFT-1:0] pos;
  } scan_hit_t;

endpackage

// ===== sv/bitmap_first_fit_page_allocator_core.sv =====
// Top level of the bitmap first-fit page allocator: busy map in a word RAM,
// sequencer for search, mark and free. Depends on bffpa_pkg, bffpa_ram, bffpa_word_scan.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | in_kind_i, in_page_count_i, in_address_i
//  out     | output    | out_valid_o / out_stall_i | out_status_o, out_granted_address_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// An allocate reads the map words in order up to the one that holds the run's last page,
// then rewrites the words the run spans; the search reads and the marking rewrites one
// 32-bit word per cycle. A failed search reads every word up to that of the last of the
// T pool pages; a refused count reads none. A free rewrites the words of its clipped range,
// none for zero pages or if refused. After reset a clearing pass writes ceil(POOL_PAGES/32)
// words (1024 by default) with in_stall_o high; configuration writes are taken at any time.
// The result register lets the next transfer in while the previous result is stalled.
module bitmap_first_fit_page_allocator_core #(
  parameter int unsigned POOL_PAGES = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_kind_i,
  input  logic [15:0] in_page_count_i,
  input  logic [63:0] in_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_status_o,
  output logic [63:0] out_granted_address_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned WB = bffpa_pkg::WORD_BITS;
  localparam int unsigned WS = bffpa_pkg::WORD_SHIFT;
  localparam int unsigned NW = (POOL_PAGES + WB - 1) / WB;
  localparam int unsigned AW = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned XW = (AW + WS + 1 > 17) ? AW + WS + 1 : 17;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SCAN, S_GRANT, S_ADDR,
    S_FREE_SUB, S_FREE_CHK, S_FREE_END, S_MOD, S_OUT
  } state_e;

  // Configuration registers.
  logic [63:0] base_q;
  logic [15:0] pages_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      pages_q <= bffpa_pkg::POOL_PAGES_RESET;
    end else if (cfg_valid_i) begin
      case (bffpa_pkg::cfg_index_e'(cfg_index_i))
        bffpa_pkg::CFG_POOL_BASE:  base_q  <= cfg_data_i;
        bffpa_pkg::CFG_POOL_PAGES: pages_q <= cfg_data_i[15:0];
        default:                   base_q  <= base_q;
      endcase
    end
  end

  logic [XW-1:0] eff_total;
  assign eff_total = (XW'(pages_q) > XW'(POOL_PAGES)) ? XW'(POOL_PAGES) : XW'(pages_q);

  state_e               state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;
  bffpa_pkg::kind_e     kind_q, kind_d;
  logic [XW-1:0]        count_q, count_d;
  logic [63:0]          addr_q, addr_d;
  logic [XW-1:0]        total_q, total_d;
  logic [AW:0]          scan_rd_q, scan_rd_d;
  logic                 ev_valid_q, ev_valid_d;
  logic [AW-1:0]        ev_w_q, ev_w_d;
  logic [XW-1:0]        run_q, run_d;
  logic [AW-1:0]        last_w_q, last_w_d;
  logic [AW-1:0]        hit_w_q, hit_w_d;
  logic [WS-1:0]        hit_b_q, hit_b_d;
  logic                 below_q, below_d;
  logic [63:0]          diff_q, diff_d;
  logic [XW-1:0]        lo_q, lo_d;
  logic [XW-1:0]        hi_q, hi_d;
  logic                 set_q, set_d;
  logic [AW:0]          mod_rd_q, mod_rd_d;
  logic                 mv_q, mv_d;
  logic [AW-1:0]        mw_q, mw_d;
  bffpa_pkg::status_e   res_status_q, res_status_d;
  logic [63:0]          res_addr_q, res_addr_d;
  logic                 out_valid_q, out_valid_d;
  bffpa_pkg::status_e   out_status_q, out_status_d;
  logic [63:0]          out_addr_q, out_addr_d;

  // Map RAM ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WB-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [WB-1:0] ram_rdata;

  bffpa_ram #(
    .WIDTH(WB),
    .DEPTH(NW)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  bffpa_pkg::scan_hit_t scan_hit;
  logic [XW-1:0]        scan_run;

  bffpa_word_scan #(
    .AW(AW),
    .XW(XW)
  ) u_word_scan (
    .word_i    (ram_rdata),
    .word_idx_i(ev_w_q),
    .total_i   (total_q),
    .count_i   (count_q),
    .run_i     (run_q),
    .hit_o     (scan_hit),
    .run_o     (scan_run)
  );

  // Range helpers for the read-modify-write sweep over [lo_q, hi_q).
  logic [XW-1:0] hi_m1;
  logic [AW-1:0] lo_w, hi_w;
  logic [WB-1:0] lo_mask, hi_mask, mod_mask;
  logic          scan_issue, mod_issue;
  logic [64:0]   sub_full;
  logic [XW-1:0] idx_hit, free_sum;

  assign hi_m1    = hi_q - XW'(1);
  assign lo_w     = AW'(lo_q >> WS);
  assign hi_w     = AW'(hi_m1 >> WS);
  assign lo_mask  = (mw_q == lo_w) ? ({WB{1'b1}} << lo_q[WS-1:0]) : {WB{1'b1}};
  assign hi_mask  = (mw_q == hi_w) ? ({WB{1'b1}} >> (WS'(WB - 1) - hi_m1[WS-1:0]))
                                   : {WB{1'b1}};
  assign mod_mask = lo_mask & hi_mask;

  assign scan_issue = (state_q == S_SCAN) && (scan_rd_q <= {1'b0, last_w_q});
  assign mod_issue  = (state_q == S_MOD) && (mod_rd_q <= {1'b0, hi_w});

  assign sub_full = {1'b0, addr_q} - {1'b0, base_q};
  assign idx_hit  = XW'({hit_w_q, hit_b_q});
  assign free_sum = lo_q + count_q;

  assign in_stall_o            = (state_q != S_IDLE);
  assign out_valid_o           = out_valid_q;
  assign out_status_o          = out_status_q;
  assign out_granted_address_o = out_addr_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    kind_d       = kind_q;
    count_d      = count_q;
    addr_d       = addr_q;
    total_d      = total_q;
    scan_rd_d    = scan_rd_q;
    ev_valid_d   = 1'b0;
    ev_w_d       = ev_w_q;
    run_d        = run_q;
    last_w_d     = last_w_q;
    hit_w_d      = hit_w_q;
    hit_b_d      = hit_b_q;
    below_d      = below_q;
    diff_d       = diff_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    set_d        = set_q;
    mod_rd_d     = mod_rd_q;
    mv_d         = 1'b0;
    mw_d         = mw_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;

    ram_we    = 1'b0;
    ram_waddr = mw_q;
    ram_wdata = set_q ? (ram_rdata | mod_mask) : (ram_rdata & ~mod_mask);
    ram_re    = scan_issue || mod_issue;
    ram_raddr = (state_q == S_SCAN) ? scan_rd_q[AW-1:0] : mod_rd_q[AW-1:0];

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(NW - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = bffpa_pkg::kind_e'(in_kind_i);
          count_d = XW'(in_page_count_i);
          addr_d  = in_address_i;
          total_d = eff_total;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        res_addr_d = '0;
        if (kind_q == bffpa_pkg::KIND_FREE) begin
          state_d = S_FREE_SUB;
        end else if ((count_q == '0) || (count_q > total_q)) begin
          res_status_d = bffpa_pkg::ST_BAD_COUNT;
          state_d      = S_OUT;
        end else begin
          scan_rd_d = '0;
          run_d     = '0;
          last_w_d  = AW'((total_q - XW'(1)) >> WS);
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        // Reads run one word ahead of the evaluation; nothing is written here.
        if (scan_issue) begin
          scan_rd_d  = scan_rd_q + (AW+1)'(1);
          ev_valid_d = 1'b1;
          ev_w_d     = scan_rd_q[AW-1:0];
        end
        if (ev_valid_q) begin
          if (scan_hit.hit) begin
            hit_w_d    = ev_w_q;
            hit_b_d    = scan_hit.pos;
            ev_valid_d = 1'b0;
            state_d    = S_GRANT;
          end else if (ev_w_q == last_w_q) begin
            res_status_d = bffpa_pkg::ST_EXHAUSTED;
            state_d      = S_OUT;
          end else begin
            run_d = scan_run;
          end
        end
      end
      S_GRANT: begin
        hi_d    = idx_hit + XW'(1);
        lo_d    = idx_hit + XW'(1) - count_q;
        state_d = S_ADDR;
      end
      S_ADDR: begin
        res_status_d = bffpa_pkg::ST_OK;
        res_addr_d   = base_q + (64'(lo_q) << bffpa_pkg::PAGE_SHIFT);
        set_d        = 1'b1;
        mod_rd_d     = (AW+1)'(lo_w);
        state_d      = S_MOD;
      end
      S_FREE_SUB: begin
        below_d = sub_full[64];
        diff_d  = sub_full[63:0];
        state_d = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (below_q || (diff_q[63:bffpa_pkg::PAGE_SHIFT] >=
                        (64 - bffpa_pkg::PAGE_SHIFT)'(total_q))) begin
          res_status_d = bffpa_pkg::ST_OUTSIDE;
          state_d      = S_OUT;
        end else begin
          lo_d    = XW'(diff_q[63:bffpa_pkg::PAGE_SHIFT]);
          state_d = S_FREE_END;
        end
      end
      S_FREE_END: begin
        res_status_d = bffpa_pkg::ST_OK;
        hi_d         = (free_sum > total_q) ? total_q : free_sum;
        set_d        = 1'b0;
        mod_rd_d     = (AW+1)'(lo_w);
        state_d      = (count_q == '0) ? S_OUT : S_MOD;
      end
      S_MOD: begin
        // The read pointer is always one word ahead of the write-back, so a read
        // never meets the word being written.
        if (mod_issue) begin
          mod_rd_d = mod_rd_q + (AW+1)'(1);
          mv_d     = 1'b1;
          mw_d     = mod_rd_q[AW-1:0];
        end
        if (mv_q) begin
          ram_we = 1'b1;
          if (mw_q == hi_w) begin
            mv_d    = 1'b0;
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      kind_q       <= bffpa_pkg::KIND_ALLOC;
      count_q      <= '0;
      addr_q       <= '0;
      total_q      <= '0;
      scan_rd_q    <= '0;
      ev_valid_q   <= 1'b0;
      ev_w_q       <= '0;
      run_q        <= '0;
      last_w_q     <= '0;
      hit_w_q      <= '0;
      hit_b_q      <= '0;
      below_q      <= 1'b0;
      diff_q       <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      set_q        <= 1'b0;
      mod_rd_q     <= '0;
      mv_q         <= 1'b0;
      mw_q         <= '0;
      res_status_q <= bffpa_pkg::ST_OK;
      res_addr_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= bffpa_pkg::ST_OK;
      out_addr_q   <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      kind_q       <= kind_d;
      count_q      <= count_d;
      addr_q       <= addr_d;
      total_q      <= total_d;
      scan_rd_q    <= scan_rd_d;
      ev_valid_q   <= ev_valid_d;
      ev_w_q       <= ev_w_d;
      run_q        <= run_d;
      last_w_q     <= last_w_d;
      hit_w_q      <= hit_w_d;
      hit_b_q      <= hit_b_d;
      below_q      <= below_d;
      diff_q       <= diff_d;
      lo_q         <= lo_d;
      hi_q         <= hi_d;
      set_q        <= set_d;
      mod_rd_q     <= mod_rd_d;
      mv_q         <= mv_d;
      mw_q         <= mw_d;
      res_status_q <= res_status_d;
      res_addr_q   <= res_addr_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_addr_q   <= out_addr_d;
    end
  end

  a_no_rmw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv_q && mod_issue) |-> (ram_raddr != mw_q))
    else $error("map read and write-back hit the same word");

  a_scan_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !ram_we)
    else $error("map written during the search");

  a_mod_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == S_MOD) |-> ((mw_q >= lo_w) && (mw_q <= hi_w)))
    else $error("map write outside the requested page range");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o != bffpa_pkg::ST_OK) |-> (out_granted_address_o == '0))
    else $error("failed request carries a nonzero address");

endmodule

// ===== sv/bffpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module bffpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== sv/bffpa_word_scan.sv =====
// Evaluates one 32-bit word of the busy map for the first-fit search: free-run
// lengths per bit through a log-depth prefix, first bit that completes the run.
// Depends on bffpa_pkg.
module bffpa_word_scan #(
  parameter int unsigned AW = 10,
  parameter int unsigned XW = 17
) (
  input  logic [bffpa_pkg::WORD_BITS-1:0] word_i,
  input  logic [AW-1:0]                   word_idx_i,
  input  logic [XW-1:0]                   total_i,
  input  logic [XW-1:0]                   count_i,
  input  logic [XW-1:0]                   run_i,
  output bffpa_pkg::scan_hit_t            hit_o,
  output logic [XW-1:0]                   run_o
);

  localparam int unsigned WB = bffpa_pkg::WORD_BITS;
  localparam int unsigned WS = bffpa_pkg::WORD_SHIFT;

  // lv/lp: whether a busy page lies at or below bit j in this word, and the
  // highest such bit, built up one doubling distance per level.
  logic          lv    [WS+1][WB];
  logic [WS-1:0] lp    [WS+1][WB];
  logic [XW-1:0] gidx  [WB];
  logic [XW-1:0] run_j [WB];
  logic [WB-1:0] match;

  always_comb begin
    for (int j = 0; j < WB; j++) begin
      gidx[j]  = XW'({word_idx_i, WS'(j)});
      // Pages at or past the pool end count as busy.
      lv[0][j] = word_i[j] | (gidx[j] >= total_i);
      lp[0][j] = WS'(j);
    end
    for (int s = 0; s < WS; s++) begin
      for (int j = 0; j < WB; j++) begin
        if (!lv[s][j] && (j >= (1 << s))) begin
          lv[s+1][j] = lv[s][(j >= (1 << s)) ? j - (1 << s) : j];
          lp[s+1][j] = lp[s][(j >= (1 << s)) ? j - (1 << s) : j];
        end else begin
          lv[s+1][j] = lv[s][j];
          lp[s+1][j] = lp[s][j];
        end
      end
    end
    for (int j = 0; j < WB; j++) begin
      run_j[j] = lv[WS][j] ? XW'(WS'(j) - lp[WS][j]) : run_i + XW'(j + 1);
      match[j] = (run_j[j] >= count_i);
    end
    hit_o.hit = |match;
    hit_o.pos = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit_o.pos = WS'(j);
      end
    end
    run_o = lv[WS][WB-1] ? XW'(WS'(WB - 1) - lp[WS][WB-1]) : run_i + XW'(WB);
  end

endmodule

// ===== tb/sv/page_alloc_checker.sv =====
// Watches the request, reply and register channels of the page allocator, keeps
// its own busy map and compares every reply with the predicted one.
// Depends on bffpa_pkg for the status, kind and register index codes.
module page_alloc_checker
  import bffpa_pkg::*;
#(
  parameter int POOL_PAGES = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        in_kind_i,
  input  logic [15:0] in_page_count_i,
  input  logic [63:0] in_address_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  out_status_i,
  input  logic [63:0] out_granted_address_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        finish_i,
  output int          owed_o,
  output int          mismatches_o,
  output int          grants_o,
  output int          exhausted_o,
  output int          frees_o,
  output int          refusals_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_e     status;
    logic [63:0] granted;
  } page_reply_t;

  bit          page_busy [POOL_PAGES];
  logic [63:0] pool_base;
  logic [15:0] pool_pages;
  page_reply_t owed_replies [$];
  int          mismatch_count;
  int          grant_count;
  int          exhausted_count;
  int          free_count;
  int          refusal_count;
  bit          end_checked;

  assign mismatches_o = mismatch_count;
  assign grants_o     = grant_count;
  assign exhausted_o  = exhausted_count;
  assign frees_o      = free_count;
  assign refusals_o   = refusal_count;

  task automatic flag(input string msg);
    $display("[%0t ns] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int usable_pages();
    return (int'(pool_pages) > POOL_PAGES) ? POOL_PAGES : int'(pool_pages);
  endfunction

  // Applies one request to the local busy map and returns the reply it must produce.
  function automatic page_reply_t apply_to_busy_map(input kind_e kind, input logic [15:0] count,
                                                    input logic [63:0] addr);
    page_reply_t reply;
    int          total;
    int          run;
    int          first;
    int          k;
    logic [63:0] offset;
    reply.status  = ST_OK;
    reply.granted = '0;
    total = usable_pages();
    if (kind == KIND_ALLOC) begin
      if (count == 0 || int'(count) > total) begin
        reply.status = ST_BAD_COUNT;
        return reply;
      end
      run = 0;
      for (int p = 0; p < total; p++) begin
        if (page_busy[p]) begin
          run = 0;
        end else begin
          run++;
          if (run == int'(count)) begin
            first = p + 1 - int'(count);
            for (k = first; k <= p; k++) page_busy[k] = 1'b1;
            reply.granted = pool_base + (64'(first) << PAGE_SHIFT);
            return reply;
          end
        end
      end
      reply.status = ST_EXHAUSTED;
      return reply;
    end
    if (addr < pool_base) begin
      reply.status = ST_OUTSIDE;
      return reply;
    end
    // The page offset is taken after the base check, so it never wraps.
    offset = (addr - pool_base) >> PAGE_SHIFT;
    if (offset >= 64'(total)) begin
      reply.status = ST_OUTSIDE;
      return reply;
    end
    first = int'(offset);
    for (k = 0; k < int'(count) && first + k < total; k++) page_busy[first + k] = 1'b0;
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    page_reply_t want;
    if (!rst_ni) begin
      page_busy  = '{default: 1'b0};
      pool_base  = '0;
      pool_pages = POOL_PAGES_RESET;
      owed_replies.delete();
      end_checked = 1'b0;
      owed_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_POOL_BASE) pool_base = cfg_data_i;
        else pool_pages = cfg_data_i[15:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (owed_replies.size() == 0) begin
          flag($sformatf("reply status %0d address %h with no request outstanding",
                         out_status_i, out_granted_address_i));
        end else begin
          want = owed_replies.pop_front();
          if (out_status_i !== want.status)
            flag($sformatf("status %0d, expected %s", out_status_i, want.status.name()));
          if (out_granted_address_i !== want.granted)
            flag($sformatf("granted address %h, expected %h", out_granted_address_i,
                           want.granted));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = apply_to_busy_map(kind_e'(in_kind_i), in_page_count_i, in_address_i);
        case (want.status)
          ST_OK: begin
            if (in_kind_i == KIND_ALLOC) grant_count++;
            else free_count++;
          end
          ST_EXHAUSTED: exhausted_count++;
          default: refusal_count++;
        endcase
        owed_replies.push_back(want);
      end
      if (finish_i && !end_checked) begin
        end_checked = 1'b1;
        if (owed_replies.size() != 0)
          flag($sformatf("%0d replies still owed at end of run", owed_replies.size()));
      end
      owed_o <= owed_replies.size();
    end
  end

endmodule

// ===== tb/sv/bitmap_first_fit_page_allocator_core_tb.sv =====
// Top of the page allocator testbench: clock, reset, request and register stimulus,
// random reply back-pressure and the verdict. Depends on bffpa_pkg, the core and page_alloc_checker.
module bitmap_first_fit_page_allocator_core_tb;
  import bffpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_PAGES   = 32768;
  localparam int RANDOM_ITEMS = 950;
  localparam int PAGE_BYTES   = 4096;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        in_kind_i;
  logic [15:0] in_page_count_i;
  logic [63:0] in_address_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  out_status_o;
  logic [63:0] out_granted_address_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        finish_check;

  int owed;
  int mismatches;
  int grants;
  int exhausted;
  int frees;
  int refusals;

  int items_sent;
  int burst_left;
  int settings_used;

  always #2 clk_i = ~clk_i;

  bitmap_first_fit_page_allocator_core #(
    .POOL_PAGES(POOL_PAGES)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .in_kind_i            (in_kind_i),
    .in_page_count_i      (in_page_count_i),
    .in_address_i         (in_address_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_status_o         (out_status_o),
    .out_granted_address_o(out_granted_address_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  page_alloc_checker #(
    .POOL_PAGES(POOL_PAGES)
  ) u_monitor (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_i           (in_stall_o),
    .in_kind_i            (in_kind_i),
    .in_page_count_i      (in_page_count_i),
    .in_address_i         (in_address_i),
    .out_valid_i          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_status_i         (out_status_o),
    .out_granted_address_i(out_granted_address_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_i          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .finish_i             (finish_check),
    .owed_o               (owed),
    .mismatches_o         (mismatches),
    .grants_o             (grants),
    .exhausted_o          (exhausted),
    .frees_o              (frees),
    .refusals_o           (refusals)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Presents one request and returns at the edge where it transfers; valid stays high.
  task automatic send_op(input kind_e kind, input int count, input logic [63:0] addr);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(15, 40);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_kind_i       <= kind;
    in_page_count_i <= 16'(count);
    in_address_i    <= addr;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Holds off new requests until every outstanding reply has transferred.
  task automatic wait_for_replies();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (owed != 0);
  endtask

  // Writes both pool registers once the allocator has gone idle.
  task automatic program_pool(input logic [63:0] base, input logic [15:0] pages);
    wait_for_replies();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_POOL_BASE;
    cfg_data_i  <= base;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_POOL_PAGES;
    cfg_data_i  <= 64'(pages);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      int hold;
      if ($urandom_range(0, 19) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(100, 200)) @(posedge clk_i);
      end
      hold = pick_gap();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [63:0] base;
    logic [63:0] top_base;
    logic [15:0] pages;
    int          total;
    int          span;
    int          phase_len;
    int          random_sent;
    int          r;
    int          page;
    int          count;
    int          guard;

    items_sent      = 0;
    burst_left      = 0;
    settings_used   = 0;
    random_sent     = 0;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    in_kind_i       <= KIND_ALLOC;
    in_page_count_i <= '0;
    in_address_i    <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_POOL_BASE;
    cfg_data_i      <= '0;
    finish_check    <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on a full-size pool.
    base     = 64'h0000_0000_8000_0000;
    top_base = 64'hFFFF_FFFF_FFFF_F000;
    program_pool(base, 16'd32768);
    send_op(KIND_ALLOC, 0, {$urandom, $urandom});
    send_op(KIND_ALLOC, 1, {$urandom, $urandom});
    send_op(KIND_ALLOC, 3, {$urandom, $urandom});
    send_op(KIND_FREE, 1, base + 64'h1123);
    send_op(KIND_FREE, 1, base - 64'd1);
    send_op(KIND_FREE, 1, base + 64'(POOL_PAGES) * PAGE_BYTES);
    send_op(KIND_FREE, 0, base);
    send_op(KIND_FREE, 5, base + 64'd100 * PAGE_BYTES);
    send_op(KIND_ALLOC, 32768, {$urandom, $urandom});
    send_op(KIND_FREE, 32768, base);
    send_op(KIND_ALLOC, 32768, {$urandom, $urandom});
    send_op(KIND_ALLOC, 1, {$urandom, $urandom});
    send_op(KIND_FREE, 16, base + 64'(POOL_PAGES - 1) * PAGE_BYTES);
    send_op(KIND_FREE, 32768, base);
    // An empty pool refuses everything.
    program_pool(64'd0, 16'd0);
    send_op(KIND_ALLOC, 1, {$urandom, $urandom});
    send_op(KIND_FREE, 1, 64'd0);
    // A pool at the top of the address space wraps its granted addresses.
    program_pool(top_base, 16'd8);
    send_op(KIND_ALLOC, 2, {$urandom, $urandom});
    send_op(KIND_ALLOC, 1, {$urandom, $urandom});
    send_op(KIND_ALLOC, 9, {$urandom, $urandom});
    send_op(KIND_FREE, 1, 64'd0);
    send_op(KIND_FREE, 8, top_base);
    // Busy pages beyond a shrunk pool survive until it grows again.
    program_pool(64'd0, 16'd16);
    send_op(KIND_ALLOC, 16, {$urandom, $urandom});
    program_pool(64'd0, 16'd4);
    send_op(KIND_FREE, 16, 64'd0);
    send_op(KIND_ALLOC, 4, {$urandom, $urandom});
    program_pool(64'd0, 16'd16);
    send_op(KIND_ALLOC, 1, {$urandom, $urandom});
    send_op(KIND_FREE, 16, 64'd0);

    // Random phases, each with its own pool setting.
    while (random_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 5) pages = 16'd0;
      else if (r < 12) pages = 16'd1;
      else if (r < 20) pages = 16'd32768;
      else if (r < 60) pages = 16'($urandom_range(2, 64));
      else pages = 16'($urandom_range(65, 1024));
      r = $urandom_range(0, 99);
      if (r < 15) base = 64'd0;
      else if (r < 25) base = top_base - 64'($urandom_range(0, 64)) * PAGE_BYTES;
      else base = {$urandom, $urandom} & ~64'hFFF;
      program_pool(base, pages);
      total     = (int'(pages) > POOL_PAGES) ? POOL_PAGES : int'(pages);
      span      = (total > 1024) ? 64 : ((total < 4) ? 1 : total / 4);
      phase_len = (total == 0) ? 12 : $urandom_range(30, 90);
      for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          if (r == 0) count = 0;
          else if (r < 3) count = total;
          else if (r < 5 && total < POOL_PAGES) count = total + 1;
          else count = $urandom_range(1, span);
          send_op(KIND_ALLOC, count, {$urandom, $urandom});
        end else if (r < 88) begin
          page  = (total > 0) ? $urandom_range(0, total - 1) : $urandom_range(0, 7);
          count = (r < 53) ? $urandom_range(span, total + span) : $urandom_range(0, span);
          send_op(KIND_FREE, count,
                  base + 64'(page) * PAGE_BYTES + 64'($urandom_range(0, PAGE_BYTES - 1)));
        end else if (r < 92) begin
          send_op(KIND_FREE, $urandom_range(0, span), base - 64'($urandom_range(1, 16384)));
        end else begin
          send_op(kind_e'($urandom_range(0, 1)), $urandom_range(0, 32768), {$urandom, $urandom});
        end
        random_sent++;
        if ($urandom_range(0, 24) == 0) wait_for_replies();
      end
    end

    // Drain, then leave room for any stray reply before closing the books.
    in_valid_i <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (owed != 0 && guard < 200_000);
    repeat (2200) @(posedge clk_i);
    finish_check <= 1'b1;
    repeat (2) @(posedge clk_i);

    $display("Sent %0d requests over %0d pool settings, extremes of base and size included.",
             items_sent, settings_used);
    $display("Predicted %0d grants, %0d exhausted searches, %0d frees and %0d refusals.",
             grants, exhausted, frees, refusals);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== bitmap_first_fit_page_allocator_core.f =====
sv/bffpa_pkg.sv
sv/bffpa_ram.sv
sv/bffpa_word_scan.sv
sv/bitmap_first_fit_page_allocator_core.sv
tb/sv/page_alloc_checker.sv
tb/sv/bitmap_first_fit_page_allocator_core_tb.sv
